### rtl/dts_pkg.sv
`timescale 1ns / 1ps
// Package for the token scanner: request types, automaton state codes,
// token class codes and the keyword/operator transition and accept functions.
// No dependencies.
package dts_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } byte_req_t;

  typedef struct packed {
    logic [4:0] token_class;
    logic       last_of_run;
  } token_req_t;

  typedef logic [6:0] state_t;
  typedef logic [4:0] class_t;

  localparam state_t ST_IDLE  = 7'd0;
  localparam state_t ST_DEAD  = 7'd1;
  localparam state_t ST_SLASH = 7'd2;
  localparam state_t ST_CBODY = 7'd3;
  localparam state_t ST_CSTAR = 7'd4;
  localparam state_t ST_UNDER = 7'd5;
  localparam state_t ST_IDENT = 7'd6;
  localparam state_t ST_NUM   = 7'd7;
  localparam state_t ST_WORD  = 7'd8;

  localparam class_t CL_ERROR   = 5'd0;
  localparam class_t CL_END     = 5'd1;
  localparam class_t CL_DIVIDE  = 5'd18;
  localparam class_t CL_COMMENT = 5'd29;
  localparam class_t CL_IDENT   = 5'd30;
  localparam class_t CL_NUMBER  = 5'd31;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // first character of a fixed word from the idle state
  function automatic state_t word_start(logic [7:0] c);
    state_t s;
    s = ST_DEAD;
    case (c)
      "i": s = 7'd8;
      "p": s = 7'd13;
      "v": s = 7'd25;
      "t": s = 7'd29;
      "b": s = 7'd33;
      "f": s = 7'd37;
      "w": s = 7'd42;
      "e": s = 7'd47;
      ">": s = 7'd51;
      "<": s = 7'd54;
      "=": s = 7'd57;
      "*": s = 7'd60;
      "!": s = 7'd61;
      "+": s = 7'd63;
      "-": s = 7'd64;
      "{": s = 7'd65;
      "}": s = 7'd66;
      ";": s = 7'd67;
      ",": s = 7'd68;
      "(": s = 7'd69;
      ")": s = 7'd70;
      default: s = ST_DEAD;
    endcase
    return s;
  endfunction

  // next character inside a fixed word prefix
  function automatic state_t word_step(state_t s, logic [7:0] c);
    state_t n;
    logic [7:0] want;
    want = 8'h00;
    n = ST_DEAD;
    case (s)
      7'd8: begin
        if (c == "f") n = 7'd9;
        else if (c == "n") n = 7'd11;
      end
      7'd14: begin
        if (c == "o") n = 7'd15;
        else if (c == "i") n = 7'd22;
      end
      default: begin
        case (s)
          7'd11: want = "t";
          7'd13: want = "r";
          7'd15: want = "g";
          7'd16: want = "r";
          7'd17: want = "a";
          7'd18: want = "m";
          7'd22: want = "n";
          7'd23: want = "t";
          7'd25: want = "o";
          7'd26: want = "i";
          7'd27: want = "d";
          7'd29: want = "r";
          7'd30: want = "u";
          7'd31: want = "e";
          7'd33: want = "o";
          7'd34: want = "o";
          7'd35: want = "l";
          7'd37: want = "a";
          7'd38: want = "l";
          7'd39: want = "s";
          7'd40: want = "e";
          7'd42: want = "h";
          7'd43: want = "i";
          7'd44: want = "l";
          7'd45: want = "e";
          7'd47: want = "l";
          7'd48: want = "s";
          7'd49: want = "e";
          7'd51: want = "=";
          7'd54: want = "=";
          7'd57: want = "=";
          7'd61: want = "=";
          default: want = 8'h00;
        endcase
        if (want != 8'h00 && c == want) begin
          case (s)
            7'd54:   n = 7'd56;
            7'd57:   n = 7'd59;
            default: n = 7'(s + 7'd1);
          endcase
        end
      end
    endcase
    return n;
  endfunction

  // class of a lexeme that ends in state s (comment states excluded)
  function automatic class_t close_class(state_t s);
    class_t k;
    case (s)
      ST_SLASH: k = CL_DIVIDE;
      ST_IDENT: k = CL_IDENT;
      ST_NUM:   k = CL_NUMBER;
      7'd9:     k = 5'd2;
      7'd12:    k = 5'd3;
      7'd19:    k = 5'd4;
      7'd24:    k = 5'd5;
      7'd28:    k = 5'd6;
      7'd32:    k = 5'd7;
      7'd36:    k = 5'd8;
      7'd41:    k = 5'd9;
      7'd46:    k = 5'd10;
      7'd50:    k = 5'd11;
      7'd52:    k = 5'd12;
      7'd51:    k = 5'd13;
      7'd54:    k = 5'd14;
      7'd56:    k = 5'd15;
      7'd57:    k = 5'd16;
      7'd59:    k = 5'd17;
      7'd60:    k = 5'd19;
      7'd62:    k = 5'd20;
      7'd63:    k = 5'd21;
      7'd64:    k = 5'd22;
      7'd65:    k = 5'd23;
      7'd66:    k = 5'd24;
      7'd67:    k = 5'd25;
      7'd68:    k = 5'd26;
      7'd69:    k = 5'd27;
      7'd70:    k = 5'd28;
      default:  k = CL_ERROR;
    endcase
    return k;
  endfunction

endpackage

### rtl/dfa_token_scanner_unit.sv
`timescale 1ns / 1ps
// Byte-serial lexical scanner: one automaton step per accepted byte request,
// token requests leave through a three-entry result queue. Uses dts_pkg.
//
// channel   dir  handshake                 payload
// byte      in   byte_valid / byte_stall   byte_req  (text_byte, end_of_text)
// token     out  token_valid / token_stall token_req (token_class, last_of_run)
//
// One byte request per cycle unless stalled; the automaton step and class
// decode sit between state register and result queue. End of text can add a
// second token request, drained one per cycle unless stalled. byte_stall rises
// while two or more results wait. Synchronous rst clears automaton, halt flag
// and queue. After an error or end token, byte requests are taken and dropped.
module dfa_token_scanner_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  dts_pkg::byte_req_t    byte_req,
  output logic                  token_valid,
  input  logic                  token_stall,
  output dts_pkg::token_req_t   token_req
);
  import dts_pkg::*;

  state_t     state;
  logic       halted;
  logic [1:0] cnt;
  token_req_t q [3];

  logic [7:0] c;
  logic       fin, accept, pop, delim, digit, letter;
  state_t     s1, sfin;
  logic       e1v, halt1, p2, kv, kerr, endv;
  class_t     e1c, k;
  token_req_t r0, r1;
  logic [1:0] n, base, cnt_next;
  token_req_t sh [3];
  token_req_t q_next [3];

  assign c      = byte_req.text_byte;
  assign fin    = (c == 8'h00) || byte_req.end_of_text;
  assign accept = byte_valid && !byte_stall;
  assign pop    = token_valid && !token_stall;
  assign delim  = (c == CH_SPACE) || (c < 8'd32) || (c == CH_DEL);
  assign digit  = (c >= "0") && (c <= "9");
  assign letter = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));

  // one scan step
  always_comb begin
    s1  = state;
    e1v = 1'b0;
    e1c = CL_ERROR;
    if (c != 8'h00) begin
      if (state == ST_CBODY) begin
        if (c == CH_STAR) s1 = ST_CSTAR;
      end else if (state == ST_CSTAR) begin
        if (c == CH_SLASH) begin
          s1  = ST_IDLE;
          e1v = 1'b1;
          e1c = CL_COMMENT;
        end else if (c != CH_STAR) begin
          s1 = ST_CBODY;
        end
      end else if (delim) begin
        if (state != ST_IDLE) begin
          s1  = ST_IDLE;
          e1v = 1'b1;
          e1c = close_class(state);
        end
      end else if (state == ST_IDLE) begin
        if (c == CH_SLASH) s1 = ST_SLASH;
        else if (c == CH_UNDER) s1 = ST_UNDER;
        else if (digit) s1 = ST_NUM;
        else s1 = word_start(c);
      end else if (state == ST_SLASH) begin
        s1 = (c == CH_STAR) ? ST_CBODY : ST_DEAD;
      end else if (state == ST_UNDER || state == ST_IDENT) begin
        s1 = letter ? ST_IDENT : ST_DEAD;
      end else if (state == ST_NUM) begin
        s1 = digit ? ST_NUM : ST_DEAD;
      end else if (state >= ST_WORD) begin
        s1 = word_step(state, c);
      end else begin
        s1 = ST_DEAD;
      end
    end
  end

  // end-of-text handling and result packing
  always_comb begin
    halt1 = e1v && (e1c == CL_ERROR);
    p2    = fin && !halt1;
    kv    = p2 && (s1 != ST_IDLE);
    k     = (s1 == ST_CBODY || s1 == ST_CSTAR) ? CL_ERROR : close_class(s1);
    kerr  = kv && (k == CL_ERROR);
    endv  = p2 && !kerr;
    sfin  = fin ? ST_IDLE : s1;
    r0    = '{token_class: CL_END, last_of_run: 1'b1};
    r1    = '{token_class: CL_END, last_of_run: 1'b1};
    n     = 2'd0;
    if (e1v) begin
      r0.token_class = e1c;
      n = endv ? 2'd2 : 2'd1;
    end else if (kv) begin
      r0.token_class = k;
      n = endv ? 2'd2 : 2'd1;
    end else if (endv) begin
      n = 2'd1;
    end
    r0.last_of_run = (n == 2'd1);
    if (halted || !accept) n = 2'd0;
  end

  // result queue, head at entry 0
  always_comb begin
    sh[0] = pop ? q[1] : q[0];
    sh[1] = pop ? q[2] : q[1];
    sh[2] = q[2];
    base  = 2'(cnt - {1'b0, pop});
    for (int i = 0; i < 3; i++) begin
      if (n != 2'd0 && 2'(i) == base) q_next[i] = r0;
      else if (n == 2'd2 && 2'(i) == 2'(base + 2'd1)) q_next[i] = r1;
      else q_next[i] = sh[i];
    end
    cnt_next = 2'(base + n);
  end

  assign byte_stall  = cnt[1];
  assign token_valid = (cnt != 2'd0);
  assign token_req   = q[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      halted <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      cnt <= cnt_next;
      if (accept && !halted) begin
        state  <= sfin;
        halted <= halt1 || p2;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) q[i] <= q_next[i];
  end

endmodule
